FILE: rtl/sfcal_pkg.sv
// Shared types and constants for the six-face accel/gyro calibration block.
// No dependencies; imported by the top level and the checker.
package sfcal_pkg;

    localparam int FACE_COUNT = 6;
    localparam int AXES       = 3;
    localparam int DATA_W     = 32;
    localparam int GRAV_W     = 31;
    localparam int SCALE_W    = 18;
    localparam int SUM_W      = 35;
    localparam int FACE_W     = 3;
    localparam int AXIS_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_W      = GRAV_W;
    localparam int FACE_AW    = $clog2(FACE_COUNT);
    localparam int GDIV_W     = 3;

    localparam int S_TDATA_W  = 6 * DATA_W;
    localparam int S_TUSER_W  = FACE_W;
    localparam int M_DATA_W   = 2 * DATA_W + SCALE_W;
    localparam int M_TDATA_W  = ((M_DATA_W + 7) / 8) * 8;
    localparam int M_TUSER_W  = AXIS_W + STATUS_W;

    localparam logic [GRAV_W-1:0]  GRAVITY_RST = 31'd642690;
    localparam logic [SCALE_W-1:0] LOWER_RST   = 18'd32768;
    localparam logic [SCALE_W-1:0] UPPER_RST   = 18'd131072;
    localparam logic [GDIV_W-1:0]  GYRO_DIV    = 3'(FACE_COUNT);
    localparam logic [SUM_W-1:0]   GYRO_HALF   = 35'(FACE_COUNT / 2);
    localparam logic [DATA_W-1:0]  BIAS_MAX    = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0]  BIAS_MIN    = 32'h8000_0000;
    localparam logic [AXIS_W-1:0]  LAST_AXIS   = 2'(AXES - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRAVITY     = 2'd0,
        REG_SCALE_LOWER = 2'd1,
        REG_SCALE_UPPER = 2'd2,
        REG_UNUSED      = 2'd3
    } cfg_reg_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_CFG   = 2'd1,
        ST_SMALL_DEN = 2'd2,
        ST_RANGE     = 2'd3
    } status_t;

    typedef struct packed {
        logic [AXIS_W-1:0]  axis;
        status_t            status;
        logic [DATA_W-1:0]  bias;
        logic [SCALE_W-1:0] scale;
        logic [DATA_W-1:0]  gyro;
        logic               last;
    } result_t;

endpackage

FILE: rtl/sfcal_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sfcal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 6
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/sfcal_div.sv
// Bit-serial restoring divider: one quotient bit per cycle, MSB first.
// Keeps the low QW quotient bits and flags any higher bit set. No dependencies.
module sfcal_div #(
    parameter int DW = 49,
    parameter int VW = 32,
    parameter int QW = 18
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          busy,
    output logic [QW-1:0] quotient,
    output logic          ovf
);

    localparam int CW = $clog2(DW + 1);

    logic          busy_reg, busy_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] dvd_reg, dvd_next;
    logic [VW-1:0] dsr_reg, dsr_next;
    logic [VW-1:0] rem_reg, rem_next;
    logic [QW-1:0] quo_reg, quo_next;
    logic          ovf_reg, ovf_next;
    logic [VW:0]   trial;
    logic [VW:0]   diff;
    logic          fits;

    assign trial = {rem_reg, dvd_reg[DW-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        ovf_next  = ovf_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(DW);
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
            quo_next  = '0;
            ovf_next  = 1'b0;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? diff[VW-1:0] : trial[VW-1:0];
            dvd_next  = {dvd_reg[DW-2:0], 1'b0};
            quo_next  = {quo_reg[QW-2:0], fits};
            ovf_next  = ovf_reg | quo_reg[QW-1];
            cnt_next  = cnt_reg - 1'b1;
            busy_next = cnt_reg != CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        ovf_reg <= ovf_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;
    assign ovf      = ovf_reg;

endmodule

FILE: rtl/six_face_accel_gyro_calibration.sv
// Six-face accelerometer and gyro calibration, top level.
// Depends on sfcal_pkg, sfcal_ram and sfcal_div.
//
// Faces arrive one per transfer on the input stream and are stored in the
// face RAM. The transfer marked tlast starts the computation: S_CHECK checks
// the settings, then for each axis the pos/neg faces are read from the face
// RAM (S_RD_POS, S_RD_NEG) and S_PREP starts the scale 2g/(pos-neg) and the
// gyro sum/6 in two bit-serial dividers side by side. S_DIV waits for both
// dividers, then S_OUT holds the result of the axis until it is taken.
// Only one calibration runs at a time; input is held off until the result
// with tlast has been taken. Errors end the results early with tlast set.
module six_face_accel_gyro_calibration import sfcal_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // face
    input  logic [S_TUSER_W-1:0] s_axis_tuser,
    input  logic                 s_axis_tlast,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // accel_bias, accel_gain, gyro_bias, zero pad
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // axis, status
    output logic [M_TUSER_W-1:0] m_axis_tuser,
    output logic                 m_axis_tlast
);

    localparam int NUM_W = DATA_W + FRAC_BITS + 1;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_CHECK  = 7'b0000010,
        S_RD_POS = 7'b0000100,
        S_RD_NEG = 7'b0001000,
        S_PREP   = 7'b0010000,
        S_DIV    = 7'b0100000,
        S_OUT    = 7'b1000000
    } state_t;

    state_t              state_reg, state_next;
    logic [AXIS_W-1:0]   axis_reg, axis_next;
    logic [GRAV_W-1:0]   gravity_reg;
    logic [SCALE_W-1:0]  lower_reg;
    logic [SCALE_W-1:0]  upper_reg;
    logic [SUM_W-1:0]    gsum_reg [AXES];
    logic [DATA_W-1:0]   pos_reg;
    logic [DATA_W-1:0]   bias_reg, bias_next;
    logic                gneg_reg, gneg_next;
    result_t             res_reg, res_next;
    logic                res_load;

    logic                s_xfer, m_xfer;
    logic                face_ok;
    logic                ram_we;
    logic [DATA_W-1:0]   ram_wdata;
    logic [FACE_AW-1:0]  ram_raddr;
    logic [DATA_W-1:0]   ram_rdata;

    logic [DATA_W:0]     den;
    logic [DATA_W:0]     bsum;
    logic [SUM_W-1:0]    gsum_sel;
    logic [SUM_W-1:0]    gmag;
    logic [NUM_W-1:0]    a_dividend;
    logic [SUM_W-1:0]    g_dividend;
    logic                div_start;
    logic                a_busy, g_busy;
    logic [SCALE_W-1:0]  a_q;
    logic                a_ovf;
    logic [DATA_W-1:0]   g_q;
    logic                g_ovf;
    logic [DATA_W-1:0]   g_sat;
    logic                cfg_bad;

    assign s_axis_tready = state_reg == S_IDLE;
    assign s_xfer        = s_axis_tvalid && s_axis_tready;
    assign m_xfer        = m_axis_tvalid && m_axis_tready;
    assign face_ok       = s_axis_tuser < FACE_W'(FACE_COUNT);

    // face store
    assign ram_we    = s_xfer && face_ok;
    assign ram_raddr = {axis_reg, state_reg == S_RD_NEG};

    always_comb
    begin
        case (s_axis_tuser[FACE_W-1:1])
            2'd0:    ram_wdata = s_axis_tdata[DATA_W-1:0];
            2'd1:    ram_wdata = s_axis_tdata[2*DATA_W-1:DATA_W];
            default: ram_wdata = s_axis_tdata[3*DATA_W-1:2*DATA_W];
        endcase
    end

    sfcal_ram #(
        .WIDTH(DATA_W),
        .DEPTH(FACE_COUNT)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(s_axis_tuser),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // per-axis arithmetic; ram_rdata holds the minus face in S_PREP
    assign den      = {pos_reg[DATA_W-1], pos_reg} - {ram_rdata[DATA_W-1], ram_rdata};
    assign bsum     = {pos_reg[DATA_W-1], pos_reg} + {ram_rdata[DATA_W-1], ram_rdata};
    assign gsum_sel = gsum_reg[axis_reg];
    assign gmag     = gsum_sel[SUM_W-1] ? (~gsum_sel + 1'b1) : gsum_sel;

    assign a_dividend = (NUM_W'(gravity_reg) << (FRAC_BITS + 1)) + NUM_W'(den[DATA_W-1:1]);
    assign g_dividend = gmag + GYRO_HALF;
    assign div_start  = state_reg == S_PREP;

    sfcal_div #(
        .DW(NUM_W),
        .VW(DATA_W),
        .QW(SCALE_W)
    ) u_div_accel (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .dividend(a_dividend),
        .divisor (den[DATA_W-1:0]),
        .busy    (a_busy),
        .quotient(a_q),
        .ovf     (a_ovf)
    );

    sfcal_div #(
        .DW(SUM_W),
        .VW(GDIV_W),
        .QW(DATA_W)
    ) u_div_gyro (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .dividend(g_dividend),
        .divisor (GYRO_DIV),
        .busy    (g_busy),
        .quotient(g_q),
        .ovf     (g_ovf)
    );

    always_comb
    begin
        if (gneg_reg)
        begin
            g_sat = (g_ovf || g_q > BIAS_MIN) ? BIAS_MIN : (~g_q + 1'b1);
        end
        else
        begin
            g_sat = (g_ovf || g_q > BIAS_MAX) ? BIAS_MAX : g_q;
        end
    end

    assign cfg_bad = (gravity_reg == '0) || (lower_reg == '0) || (upper_reg < lower_reg);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        bias_next  = bias_reg;
        gneg_next  = gneg_reg;
        res_load   = 1'b0;
        res_next   = res_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_xfer && s_axis_tlast)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                axis_next = '0;
                if (cfg_bad)
                begin
                    res_load   = 1'b1;
                    res_next   = '{axis: '0, status: ST_BAD_CFG, bias: '0, scale: '0,
                                   gyro: '0, last: 1'b1};
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_RD_POS;
                end
            end
            S_RD_POS:
            begin
                state_next = S_RD_NEG;
            end
            S_RD_NEG:
            begin
                state_next = S_PREP;
            end
            S_PREP:
            begin
                bias_next = bsum[DATA_W:1];
                gneg_next = gsum_sel[SUM_W-1];
                if (den[DATA_W] || den[DATA_W-1:1] == '0)
                begin
                    res_load   = 1'b1;
                    res_next   = '{axis: axis_reg, status: ST_SMALL_DEN, bias: '0,
                                   scale: '0, gyro: '0, last: 1'b1};
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (!a_busy && !g_busy)
                begin
                    res_load   = 1'b1;
                    state_next = S_OUT;
                    if (a_ovf || a_q < lower_reg || a_q > upper_reg)
                    begin
                        res_next = '{axis: axis_reg, status: ST_RANGE, bias: '0,
                                     scale: '0, gyro: '0, last: 1'b1};
                    end
                    else
                    begin
                        res_next = '{axis: axis_reg, status: ST_OK, bias: bias_reg,
                                     scale: a_q, gyro: g_sat,
                                     last: axis_reg == LAST_AXIS};
                    end
                end
            end
            S_OUT:
            begin
                if (m_xfer)
                begin
                    if (res_reg.last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        axis_next  = axis_reg + 1'b1;
                        state_next = S_RD_POS;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            axis_reg    <= '0;
            gravity_reg <= GRAVITY_RST;
            lower_reg   <= LOWER_RST;
            upper_reg   <= UPPER_RST;
            for (int i = 0; i < AXES; i++)
            begin
                gsum_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_GRAVITY:     gravity_reg <= cfg_data;
                    REG_SCALE_LOWER: lower_reg   <= cfg_data[SCALE_W-1:0];
                    REG_SCALE_UPPER: upper_reg   <= cfg_data[SCALE_W-1:0];
                    default:         ;
                endcase
            end
            if (ram_we)
            begin
                for (int i = 0; i < AXES; i++)
                begin
                    gsum_reg[i] <= gsum_reg[i] + SUM_W'($signed(
                        s_axis_tdata[(AXES+i)*DATA_W +: DATA_W]));
                end
            end
            else if (state_reg == S_OUT && m_xfer && res_reg.last)
            begin
                for (int i = 0; i < AXES; i++)
                begin
                    gsum_reg[i] <= '0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_RD_NEG)
        begin
            pos_reg <= ram_rdata;
        end
        bias_reg <= bias_next;
        gneg_reg <= gneg_next;
        if (res_load)
        begin
            res_reg <= res_next;
        end
    end

    assign m_axis_tvalid = state_reg == S_OUT;
    assign m_axis_tdata  = {(M_TDATA_W - M_DATA_W)'(0), res_reg.gyro, res_reg.scale,
                            res_reg.bias};
    assign m_axis_tuser  = {res_reg.status, res_reg.axis};
    assign m_axis_tlast  = res_reg.last;

endmodule

FILE: rtl/sfcal_checker.sv
// Port-level checks for the calibration top level, bound to it below.
// Depends on sfcal_pkg and six_face_accel_gyro_calibration.
module sfcal_checker import sfcal_pkg::*; (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata,
    input logic [M_TUSER_W-1:0] m_axis_tuser,
    input logic                 m_axis_tlast
);

    // stalled result transfer holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // no new face is taken while a result is pending
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while result pending");

    // any error ends the run
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[M_TUSER_W-1:AXIS_W] != ST_OK |-> m_axis_tlast)
        else $error("error result without tlast");

    // error results carry no numbers
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[M_TUSER_W-1:AXIS_W] != ST_OK |-> m_axis_tdata == '0)
        else $error("error result with nonzero data");

    // config error reports axis 0, and no axis beyond z
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tuser[AXIS_W-1:0] != 2'd3
            && (m_axis_tuser[M_TUSER_W-1:AXIS_W] != ST_BAD_CFG
                || m_axis_tuser[AXIS_W-1:0] == '0))
        else $error("bad axis on result");

endmodule

bind six_face_accel_gyro_calibration sfcal_checker u_sfcal_checker (.*);
